[src/biquad_lowpass_filter_defines.svh]
// Assertion macros shared by the verification files of the biquad low-pass filter.
// No dependencies; expects clk and rst_n to be visible where a macro is used.
`ifndef BIQUAD_LOWPASS_FILTER_DEFINES_SVH
`define BIQUAD_LOWPASS_FILTER_DEFINES_SVH

// Consequence must hold in the same cycle as the condition.
`define BQLP_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Consequence must hold in the cycle after the condition.
`define BQLP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[src/bqlp_pkg.sv]
// Package of the biquad low-pass filter: widths, reset coefficients, control types
// and the microcode program of the sequencer. No dependencies.
package bqlp_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int COEF_W             = 18;
  localparam int DELAY_W            = 32;
  localparam int PROD_W             = DELAY_W + COEF_W;
  localparam int ACC_W              = PROD_W + 2;
  localparam int CFG_IDX_W          = 3;
  localparam int STEP_W             = 3;

  localparam logic signed [COEF_W-1:0] A1_RESET = COEF_W'(-49007);
  localparam logic signed [COEF_W-1:0] A2_RESET = COEF_W'(17840);
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(8592);
  localparam logic signed [COEF_W-1:0] B1_RESET = COEF_W'(17184);
  localparam logic signed [COEF_W-1:0] B2_RESET = COEF_W'(8592);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_ONE  = 3'd0,
    REG_FB_TWO  = 3'd1,
    REG_FF_ZERO = 3'd2,
    REG_FF_ONE  = 3'd3,
    REG_FF_TWO  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } coef_set_t;

  typedef enum logic [2:0] {CS_A1, CS_A2, CS_B0, CS_B1, CS_B2} coef_sel_t;
  typedef enum logic [1:0] {DS_D1, DS_D2, DS_W} data_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [1:0] {WAIT_NONE, WAIT_IN, WAIT_OUT} wait_t;

  typedef enum logic [STEP_W-1:0] {
    ST_TAKE    = 3'd0,
    ST_FB_LOAD = 3'd1,
    ST_FB_ADD  = 3'd2,
    ST_MAKE_W  = 3'd3,
    ST_FF_ADD1 = 3'd4,
    ST_FF_ADD2 = 3'd5,
    ST_EMIT    = 3'd6
  } step_t;

  typedef struct packed {
    logic      take_in;
    logic      make_w;
    logic      emit;
    acc_op_t   acc_op;
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    wait_t     wait_on;
    logic      jump;
    step_t     target;
  } ucode_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      load_x;
    logic      make_w;
    logic      emit;
  } dp_ctrl_t;

  // The product of a step lands in the accumulator one step later.
  function automatic ucode_t ucode(input step_t step);
    ucode_t uw;
    uw = '{take_in: 1'b0, make_w: 1'b0, emit: 1'b0, acc_op: ACC_HOLD,
           coef_sel: CS_A1, data_sel: DS_D1, wait_on: WAIT_NONE,
           jump: 1'b0, target: ST_TAKE};
    case (step)
      ST_TAKE: begin
        uw.take_in  = 1'b1;
        uw.wait_on  = WAIT_IN;
        uw.coef_sel = CS_A1;
        uw.data_sel = DS_D1;
      end
      ST_FB_LOAD: begin
        uw.acc_op   = ACC_LOAD;
        uw.coef_sel = CS_A2;
        uw.data_sel = DS_D2;
      end
      ST_FB_ADD: begin
        uw.acc_op   = ACC_ADD;
        uw.coef_sel = CS_B1;
        uw.data_sel = DS_D1;
      end
      ST_MAKE_W: begin
        uw.make_w   = 1'b1;
        uw.acc_op   = ACC_LOAD;
        uw.coef_sel = CS_B2;
        uw.data_sel = DS_D2;
      end
      ST_FF_ADD1: begin
        uw.acc_op   = ACC_ADD;
        uw.coef_sel = CS_B0;
        uw.data_sel = DS_W;
      end
      ST_FF_ADD2: begin
        uw.acc_op = ACC_ADD;
      end
      ST_EMIT: begin
        uw.emit    = 1'b1;
        uw.wait_on = WAIT_OUT;
        uw.jump    = 1'b1;
        uw.target  = ST_TAKE;
      end
      default: begin
        uw.jump   = 1'b1;
        uw.target = ST_TAKE;
      end
    endcase
    return uw;
  endfunction

endpackage

[src/biquad_lowpass_filter.sv]
// Top level of the biquad low-pass filter: configuration registers, output valid
// and the sequencer and datapath instances. Depends on bqlp_pkg, bqlp_seq, bqlp_dp.
//
// Second-order IIR low-pass in direct form II on signed samples. From acceptance
// to the result register, each item runs through a seven-step program of the
// sequencer around one shared 18x32-bit multiplier and a 52-bit accumulator,
// two products for the feedback sum and three for the feedforward sum.
// A new item is taken only in the first step of the program; a finished result
// sits in its own register, so the next item is accepted while that result waits,
// and the program only pauses at its last step if the previous result has still
// not been taken. Coefficients are signed Q2.16 (COEF_FRAC_BITS fractional bits)
// and are written through the cfg port, which is always ready; writes to an index
// beyond the fifth register are ignored. Sums are rounded to nearest with ties
// upward, the delay value saturates to 32 bits and the result to SAMPLE_BITS.
// Change coefficients only while no item is in flight.
module biquad_lowpass_filter
  import bqlp_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_filtered_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]      cfg_data
);

  coef_set_t coef_r, coef_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_busy;
  dp_ctrl_t  ctrl;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FB_ONE:  coef_nxt.a1 = cfg_data;
        REG_FB_TWO:  coef_nxt.a2 = cfg_data;
        REG_FF_ZERO: coef_nxt.b0 = cfg_data;
        REG_FF_ONE:  coef_nxt.b1 = cfg_data;
        REG_FF_TWO:  coef_nxt.b2 = cfg_data;
        default:     coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '{a1: A1_RESET, a2: A2_RESET, b0: B0_RESET, b1: B1_RESET, b2: B2_RESET};
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // The result register is busy while it holds an item that is not being taken.
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  bqlp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  bqlp_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .coefs        (coef_r),
    .sample_in    (in_sample_in),
    .filtered_out (out_filtered_out)
  );

endmodule

[src/bqlp_seq.sv]
// Microcode sequencer of the biquad low-pass filter: step counter, program table
// and wait/jump handling. Depends on bqlp_pkg.
module bqlp_seq
  import bqlp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_busy,
  output logic     in_ready,
  output dp_ctrl_t ctrl
);

  step_t               step_r;
  step_t               step_nxt;
  ucode_t              uw;
  logic                stall;
  logic [STEP_W-1:0]   step_inc;

  always_comb begin
    uw       = ucode(step_r);
    stall    = ((uw.wait_on == WAIT_IN) && !in_valid) ||
               ((uw.wait_on == WAIT_OUT) && out_busy);
    step_inc = step_r + STEP_W'(1);
    if (stall) begin
      step_nxt = step_r;
    end else if (uw.jump) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_t'(step_inc);
    end
    in_ready      = uw.take_in;
    ctrl.coef_sel = uw.coef_sel;
    ctrl.data_sel = uw.data_sel;
    ctrl.acc_op   = uw.acc_op;
    ctrl.load_x   = uw.take_in && in_valid;
    ctrl.make_w   = uw.make_w;
    ctrl.emit     = uw.emit && !out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_TAKE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[src/bqlp_dp.sv]
// Datapath of the biquad low-pass filter: shared multiplier, accumulator,
// delay elements, saturation and the output payload register. Depends on bqlp_pkg.
module bqlp_dp
  import bqlp_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_ctrl_t               ctrl,
  input  coef_set_t              coefs,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic [SAMPLE_BITS-1:0] filtered_out
);

  localparam int FB_W   = ACC_W - COEF_FRAC_BITS;
  localparam int DIFF_W = ((FB_W > DELAY_W) ? FB_W : DELAY_W) + 1;
  localparam int Y_W    = (FB_W > SAMPLE_BITS) ? FB_W : SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [DELAY_W-1:0]     d1_r, d2_r, w_r, w_nxt;
  logic signed [PROD_W-1:0]      product_r, product_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic [SAMPLE_BITS-1:0]        y_r, y_nxt;
  logic signed [COEF_W-1:0]      coef_mux;
  logic signed [DELAY_W-1:0]     data_mux;
  logic signed [FB_W-1:0]        scaled;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [Y_W-1:0]         y_ext;

  always_comb begin
    case (ctrl.coef_sel)
      CS_A1:   coef_mux = coefs.a1;
      CS_A2:   coef_mux = coefs.a2;
      CS_B0:   coef_mux = coefs.b0;
      CS_B1:   coef_mux = coefs.b1;
      CS_B2:   coef_mux = coefs.b2;
      default: coef_mux = coefs.a1;
    endcase
    case (ctrl.data_sel)
      DS_D1:   data_mux = d1_r;
      DS_D2:   data_mux = d2_r;
      DS_W:    data_mux = w_r;
      default: data_mux = d1_r;
    endcase
    product_nxt = coef_mux * data_mux;

    // Loading adds the rounding half so that the shift below rounds to nearest.
    case (ctrl.acc_op)
      ACC_LOAD: acc_nxt = ACC_W'(product_r) + ROUND_HALF;
      ACC_ADD:  acc_nxt = acc_r + ACC_W'(product_r);
      default:  acc_nxt = acc_r;
    endcase

    scaled = acc_r[ACC_W-1:COEF_FRAC_BITS];

    diff = DIFF_W'(x_r) - DIFF_W'(scaled);
    if ((&diff[DIFF_W-1:DELAY_W-1]) || !(|diff[DIFF_W-1:DELAY_W-1])) begin
      w_nxt = diff[DELAY_W-1:0];
    end else begin
      w_nxt = {diff[DIFF_W-1], {(DELAY_W-1){~diff[DIFF_W-1]}}};
    end

    y_ext = Y_W'(scaled);
    if ((&y_ext[Y_W-1:SAMPLE_BITS-1]) || !(|y_ext[Y_W-1:SAMPLE_BITS-1])) begin
      y_nxt = y_ext[SAMPLE_BITS-1:0];
    end else begin
      y_nxt = {y_ext[Y_W-1], {(SAMPLE_BITS-1){~y_ext[Y_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    product_r <= product_nxt;
    acc_r     <= acc_nxt;
    if (ctrl.load_x) begin
      x_r <= sample_in;
    end
    if (ctrl.make_w) begin
      w_r <= w_nxt;
    end
    if (ctrl.emit) begin
      y_r <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (ctrl.emit) begin
      d2_r <= d1_r;
      d1_r <= w_r;
    end
  end

  assign filtered_out = y_r;

endmodule

[src/bqlp_chk.sv]
// Port-level checker of the biquad low-pass filter and its bind to the top level.
// Depends on bqlp_pkg and biquad_lowpass_filter_defines.svh.
`include "biquad_lowpass_filter_defines.svh"

module bqlp_chk
  import bqlp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_filtered_out
);

  // A result that is not taken stays, unchanged.
  `BQLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_filtered_out), "result changed while stalled")

  // Once an item is taken, the program runs on before the next can enter.
  `BQLP_ASSERT_NEXT(a_no_back_to_back, in_valid && in_ready, !in_ready, "input taken in consecutive cycles")

  // The input is still closed when the program reaches its last step after taking an item.
  `BQLP_ASSERT_NOW(a_min_latency, in_valid && in_ready, ##6 !in_ready, "item processed in fewer than seven cycles")

  // A new result appears exactly when the sequencer returns to its first step.
  `BQLP_ASSERT_NOW(a_emit_returns, $rose(out_valid), in_ready, "result issued outside the last step")

endmodule

bind biquad_lowpass_filter bqlp_chk #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bqlp_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_filtered_out (out_filtered_out)
);

[sim/tb_top.sv]
// Self-checking testbench for the biquad low-pass filter: random and directed samples,
// coefficient changes between phases, and checks of every filtered result.
// Depends on bqlp_pkg and biquad_lowpass_filter.
module tb_top;
  import bqlp_pkg::*;

  localparam int     CLK_PERIOD     = 12;
  localparam int     SW             = SAMPLE_BITS_DEF;
  localparam int     FRAC           = COEF_FRAC_BITS_DEF;
  // Allow a margin beyond the time from acceptance to the result register.
  localparam int     RESULT_LATENCY = 10;
  localparam longint TIMEOUT_CYCLES = 400000;
  localparam longint SAMPLE_MAX     = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
  localparam longint DELAY_MAX      = (longint'(1) <<< (DELAY_W - 1)) - 1;
  localparam longint DELAY_MIN      = -DELAY_MAX - 1;
  localparam int     COEF_MAX       = (1 <<< (COEF_W - 1)) - 1;
  localparam int     COEF_MIN       = -COEF_MAX - 1;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [SW-1:0]        in_sample_in     = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [SW-1:0]        out_filtered_out;
  logic                 cfg_valid        = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [COEF_W-1:0]    cfg_data         = '0;

  // Samples waiting to be offered, and filtered values waiting to come back.
  logic [SW-1:0] pending_samples[$];
  logic [SW-1:0] expected_filtered[$];
  logic [SW-1:0] filtered_want;

  int   fail_count      = 0;
  int   send_idle_pct   = 0;
  int   recv_stall_pct  = 0;
  int   hold_cycles_req = 0;
  logic rx_hold         = 1'b0;
  logic in_taken        = 1'b0;

  // The predictor's own copy of the coefficients and of the two delay elements.
  longint fb_one    = longint'(A1_RESET);
  longint fb_two    = longint'(A2_RESET);
  longint ff_zero   = longint'(B0_RESET);
  longint ff_one    = longint'(B1_RESET);
  longint ff_two    = longint'(B2_RESET);
  longint delay_one = 0;
  longint delay_two = 0;

  biquad_lowpass_filter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered_out (out_filtered_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Scale a Q2.16 sum back to sample scale, rounding to nearest with ties upward.
  // The shift is arithmetic, so it floors for negative sums as well.
  function automatic longint round_q(input longint s);
    return (s + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One step of the direct form II filter: the feedback sum makes the new delay
  // value, the feedforward sum makes the output, then the delay line shifts.
  function automatic logic [SW-1:0] biquad_step(input logic [SW-1:0] x_raw);
    longint x, w, y;
    x = longint'($signed(x_raw));
    w = saturate(x - round_q(fb_one * delay_one + fb_two * delay_two), DELAY_MIN, DELAY_MAX);
    y = round_q(ff_zero * w + ff_one * delay_one + ff_two * delay_two);
    y = saturate(y, SAMPLE_MIN, SAMPLE_MAX);
    delay_two = delay_one;
    delay_one = w;
    return y[SW-1:0];
  endfunction

  // Mostly full-range samples, with small values and the two rails mixed in.
  function automatic logic [SW-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return SW'($urandom());
    if (pick < 8) return SW'(int'($urandom_range(2000)) - 1000);
    if (pick == 8) return SW'(SAMPLE_MAX);
    return SW'(SAMPLE_MIN);
  endfunction

  // Input driver. A new item is offered only once the previous one has been
  // taken; otherwise valid and the sample stay exactly as they are.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (rst_n && pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid     <= 1'b1;
        in_sample_in <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Every accepted sample runs through the predictor right away. Coefficients only
  // change while nothing is in flight, so the current set is the one the block uses.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_filtered.push_back(biquad_step(in_sample_in));
      in_taken = 1'b1;
    end
  end

  // Receiver: random stalls, or a solid hold-off while rx_hold is set.
  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off on the output side, counted here so that the stimulus process
  // can keep feeding samples while the block backs up and drops in_ready.
  always begin
    wait (hold_cycles_req != 0);
    rx_hold = 1'b1;
    repeat (hold_cycles_req) @(posedge clk);
    rx_hold = 1'b0;
    hold_cycles_req = 0;
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_filtered.size() == 0) begin
        $error("filtered_out: unexpected result, actual %0d", $signed(out_filtered_out));
        fail_count++;
      end else begin
        filtered_want = expected_filtered.pop_front();
        if (filtered_want !== out_filtered_out) begin
          $error("filtered_out mismatch: expected %0d, actual %0d",
                 $signed(filtered_want), $signed(out_filtered_out));
          fail_count++;
        end
      end
    end
  end

  // Register write through the cfg channel; the predictor picks up the new value
  // at the handshake. Indexes past the last coefficient must leave everything alone.
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input int value);
    longint c;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[COEF_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    c = longint'($signed(value[COEF_W-1:0]));
    case (idx)
      REG_FB_ONE:  fb_one  = c;
      REG_FB_TWO:  fb_two  = c;
      REG_FF_ZERO: ff_zero = c;
      REG_FF_ONE:  ff_one  = c;
      REG_FF_TWO:  ff_two  = c;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_coefs(input int a1, input int a2, input int b0, input int b1,
                           input int b2);
    write_coef(REG_FB_ONE, a1);
    write_coef(REG_FB_TWO, a2);
    write_coef(REG_FF_ZERO, b0);
    write_coef(REG_FF_ONE, b1);
    write_coef(REG_FF_TWO, b2);
  endtask

  // Poles kept inside the unit circle (|a2| < 1, |a1| < 1 + a2), so the output
  // follows the input instead of sitting on a rail.
  task automatic set_stable_coefs();
    int a1, a2, bound;
    a2    = int'($urandom_range(120000)) - 60000;
    bound = 65535 + a2;
    a1    = int'($urandom_range(2 * bound)) - bound;
    set_coefs(a1, a2, int'($urandom_range(40000)) - 20000,
              int'($urandom_range(40000)) - 20000, int'($urandom_range(40000)) - 20000);
  endtask

  task automatic set_random_coefs();
    set_coefs(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
              int'($urandom()));
  endtask

  // The sender pauses here until every predicted result has come back.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_filtered.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) pending_samples.push_back(random_sample());
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes to the unused indexes come first; the directed samples that follow
    // then show the reset coefficients are still in place.
    for (int i = int'(REG_FF_TWO) + 1; i < (1 << CFG_IDX_W); i++)
      write_coef(CFG_IDX_W'(i), int'($urandom()));

    // Directed samples: zero, unit steps, rail-to-rail steps that overshoot into
    // output saturation, a fast alternation at the rails and checkerboard patterns.
    pending_samples.push_back(SW'(0));
    pending_samples.push_back(SW'(1));
    pending_samples.push_back(SW'(-1));
    repeat (6) pending_samples.push_back(SW'(SAMPLE_MAX));
    repeat (6) pending_samples.push_back(SW'(SAMPLE_MIN));
    repeat (3) begin
      pending_samples.push_back(SW'(SAMPLE_MAX));
      pending_samples.push_back(SW'(SAMPLE_MIN));
    end
    pending_samples.push_back(SW'('h555555));
    pending_samples.push_back(SW'('haaaaaa));
    pending_samples.push_back(SW'(0));
    wait_idle();

    // Random phases, each under its own coefficient set and idle pattern. The all-max
    // and all-min sets drive the delay line into 32-bit saturation.
    set_coefs(int'(A1_RESET), int'(A2_RESET), int'(B0_RESET), int'(B1_RESET),
              int'(B2_RESET));
    run_phase(0, 0, 120);
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    run_phase(0, 0, 60);
    set_stable_coefs();
    run_phase(47, 0, 130);
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    run_phase(0, 47, 60);
    set_random_coefs();
    run_phase(23, 23, 100);

    // Back-pressure: the output side holds off while samples keep coming, so the
    // result register and the program fill up and the input stalls.
    set_stable_coefs();
    hold_cycles_req = 300;
    run_phase(0, 0, 130);

    // Pure gain of almost two with no feedback: large samples clip at the output.
    set_coefs(0, 0, COEF_MAX, 0, 0);
    run_phase(47, 0, 60);
    set_stable_coefs();
    run_phase(0, 47, 130);
    set_stable_coefs();
    run_phase(23, 23, 130);
    set_random_coefs();
    run_phase(47, 0, 100);
    set_stable_coefs();
    run_phase(0, 47, 100);

    repeat (RESULT_LATENCY) @(posedge clk);
    if (fail_count == 0 && expected_filtered.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
